// ----- rtl/core/salc_pkg.sv -----
// Package with constants, types and helpers of the set-associative LRU cache tag block.
package salc_pkg;

    localparam int SETS_DEF      = 256;
    localparam int WAYS_DEF      = 8;
    localparam int ADDR_BITS_DEF = 32;

    localparam int MAX_OFFSET_BITS = 16;
    localparam int MAX_INDEX_BITS  = 8;
    localparam int NUM_STATS       = 8;
    localparam int CNT_W           = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 5;
    localparam int WAY_OUT_W       = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WRITE
    } ctrl_state_t;

    // Lookup outcome handed from the lookup logic to the top level.
    typedef struct packed {
        logic                 hit;
        logic                 writeback;
        logic [WAY_OUT_W-1:0] way;
    } lookup_res_t;

    // Statistics event flags for one access.
    typedef struct packed {
        logic wr;
        logic hit;
        logic wb;
    } stat_evt_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
        logic [CNT_W-1:0] r;
        r = v;
        if (en && (v != {CNT_W{1'b1}}))
        begin
            r = v + 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/salc_stats.sv -----
// Eight saturating statistics counters of the cache tag block.
module salc_stats
    import salc_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            bump,
    input  stat_evt_t                       evt,
    output logic [NUM_STATS-1:0][CNT_W-1:0] counts
);

    logic [NUM_STATS-1:0][CNT_W-1:0] cnt_reg;
    logic [NUM_STATS-1:0][CNT_W-1:0] cnt_next;

    // Each counter steps on its own event and sticks at all ones.
    always_comb
    begin
        cnt_next    = cnt_reg;
        cnt_next[0] = sat_inc(cnt_reg[0], bump);
        cnt_next[1] = sat_inc(cnt_reg[1], bump && evt.hit);
        cnt_next[2] = sat_inc(cnt_reg[2], bump && !evt.hit);
        cnt_next[3] = sat_inc(cnt_reg[3], bump && evt.wb);
        cnt_next[4] = sat_inc(cnt_reg[4], bump && !evt.wr);
        cnt_next[5] = sat_inc(cnt_reg[5], bump && evt.wr);
        cnt_next[6] = sat_inc(cnt_reg[6], bump && !evt.hit && !evt.wr);
        cnt_next[7] = sat_inc(cnt_reg[7], bump && !evt.hit && evt.wr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign counts = cnt_reg;

endmodule

// ----- rtl/core/salc_set_mem.sv -----
// Set memory: one row per set holding tag, valid, dirty and LRU rank of every way.
module salc_set_mem #(
    parameter int SETS  = 256,
    parameter int ROW_W = 8
) (
    input  logic                            clk,
    input  logic [$clog2(SETS > 1 ? SETS : 2)-1:0] rd_addr,
    output logic [ROW_W-1:0]                rd_data,
    input  logic                            wr_en,
    input  logic [$clog2(SETS > 1 ? SETS : 2)-1:0] wr_addr,
    input  logic [ROW_W-1:0]                wr_data
);

    logic [ROW_W-1:0] mem [SETS];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/salc_lookup.sv -----
// Lookup and update logic: tag compare, victim choice and LRU aging on one set row.
module salc_lookup
    import salc_pkg::*;
#(
    parameter int WAYS  = 8,
    parameter int TAG_W = 32,
    parameter int RANK_W = 3
) (
    input  logic [WAYS-1:0][TAG_W-1:0]  tags,
    input  logic [WAYS-1:0]             valid,
    input  logic [WAYS-1:0]             dirty,
    input  logic [WAYS-1:0][RANK_W-1:0] rank,
    input  logic [TAG_W-1:0]            tag,
    input  logic                        wr,
    input  logic [WAYS-1:0]             in_use,
    output lookup_res_t                 res,
    output logic [WAYS-1:0][TAG_W-1:0]  tags_new,
    output logic [WAYS-1:0]             valid_new,
    output logic [WAYS-1:0]             dirty_new,
    output logic [WAYS-1:0][RANK_W-1:0] rank_new
);

    localparam int WIDX_W = $clog2(WAYS > 1 ? WAYS : 2);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

    logic [WAYS-1:0]   match;
    logic [WAYS-1:0]   free;
    logic              hit;
    logic              found;
    logic [WIDX_W-1:0] hit_way;
    logic [WIDX_W-1:0] free_way;
    logic [WIDX_W-1:0] lru_way;
    logic [RANK_W-1:0] best;
    logic [WIDX_W-1:0] way;
    logic              was_valid;
    logic [RANK_W:0]   old_rank;

    // Parallel compares and first-one picks over the ways.
    always_comb
    begin
        hit      = 1'b0;
        found    = 1'b0;
        hit_way  = '0;
        free_way = '0;
        lru_way  = '0;
        best     = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            match[i] = in_use[i] && valid[i] && (tags[i] == tag);
            free[i]  = in_use[i] && !valid[i];
            if (match[i])
            begin
                hit     = 1'b1;
                hit_way = WIDX_W'(i);
            end
            if (free[i])
            begin
                found    = 1'b1;
                free_way = WIDX_W'(i);
            end
        end
        // Oldest way in use; the lowest way wins on a tie.
        for (int i = 0; i < WAYS; i++)
        begin
            if (in_use[i] && (rank[i] > best))
            begin
                best    = rank[i];
                lru_way = WIDX_W'(i);
            end
        end
    end

    // Chosen way, row update and LRU aging.
    always_comb
    begin
        if (hit)
        begin
            way = hit_way;
        end
        else if (found)
        begin
            way = free_way;
        end
        else
        begin
            way = lru_way;
        end
        was_valid = valid[way];
        old_rank  = was_valid ? {1'b0, rank[way]} : (RANK_W + 1)'(WAYS);

        res.hit       = hit;
        res.writeback = !hit && !found && dirty[way];
        res.way       = WAY_OUT_W'(way);

        tags_new  = tags;
        valid_new = valid;
        dirty_new = dirty;
        rank_new  = rank;
        for (int i = 0; i < WAYS; i++)
        begin
            if ((WIDX_W'(i) != way) && valid[i] && ({1'b0, rank[i]} < old_rank)
                && (rank[i] < RANK_MAX))
            begin
                rank_new[i] = rank[i] + 1'b1;
            end
        end
        rank_new[way] = '0;
        if (hit)
        begin
            dirty_new[way] = dirty[way] | wr;
        end
        else
        begin
            tags_new[way]  = tag;
            valid_new[way] = 1'b1;
            dirty_new[way] = wr;
        end
    end

endmodule

// ----- rtl/core/set_assoc_lru_cache_tags.sv -----
// Top level of the set-associative write-back LRU cache tag controller.
// After reset the block clears its set memory, one set a cycle, and accepts no word
// until every set is cleared. Each access then reads the set row from the registered
// synchronous set memory, compares and updates it, and writes it back, and a new word
// is accepted only once the previous access has been written back.
// The result waits in an output register, which lets the next access be accepted and
// looked up while it is still unread; that access holds in its lookup cycle until the
// waiting result is taken.
module set_assoc_lru_cache_tags
    import salc_pkg::*;
#(
    parameter int SETS      = SETS_DEF,
    parameter int WAYS      = WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Access stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ADDR_BITS-1:0]  s_tdata,   // address
    input  logic                  s_tuser,   // is_write
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hit, writeback, way_used[3], access_count, hit_count, miss_count,
    // writeback_count, read_count, write_count, read_miss_count, write_miss_count
    output logic [263:0]          m_tdata
);

    localparam int SET_W  = $clog2(SETS > 1 ? SETS : 2);
    localparam int TAG_W  = ADDR_BITS;
    localparam int RANK_W = $clog2(WAYS > 1 ? WAYS : 2);
    localparam int ROW_W  = WAYS * (TAG_W + 2 + RANK_W);
    localparam int SH_W   = 5;
    localparam int MOD_SH = 20;
    localparam logic [MOD_SH:0] SET_RECIP = (MOD_SH + 1)'(((1 << MOD_SH) + SETS - 1) / SETS);

    logic [4:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [3:0] ways_in_use_reg;

    ctrl_state_t          state_reg, state_next;
    logic [SET_W-1:0]     clr_reg, clr_next;
    logic [TAG_W-1:0]     tag_reg;
    logic [SET_W-1:0]     set_reg;
    logic                 wr_reg;
    logic [WAYS-1:0]      use_reg;
    lookup_res_t          res_reg;
    logic [ROW_W-1:0]     row_reg;
    logic                 out_valid_reg;
    logic [2+WAY_OUT_W-1:0] out_head_reg;

    logic [ROW_W-1:0]     rd_data;
    logic                 mem_we;
    logic [SET_W-1:0]     mem_waddr;
    logic [ROW_W-1:0]     mem_wdata;
    logic                 accept;

    logic [SH_W-1:0]      ob, ib;
    logic [ADDR_BITS-1:0] shifted;
    logic [ADDR_BITS-1:0] tag_calc;
    logic [MAX_INDEX_BITS-1:0] idx_raw;
    logic [MAX_INDEX_BITS+MOD_SH:0] idx_prod;
    logic [MAX_INDEX_BITS-1:0] idx_quot;
    logic [SET_W-1:0]     set_idx;
    logic [3:0]           n_ways;

    logic [WAYS-1:0][TAG_W-1:0]  tags, tags_new;
    logic [WAYS-1:0]             valid, valid_new, dirty, dirty_new;
    logic [WAYS-1:0][RANK_W-1:0] rank, rank_new;
    lookup_res_t                 res;
    logic [NUM_STATS-1:0][CNT_W-1:0] counts;
    stat_evt_t                   evt;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= 5'd5;
            index_bits_reg  <= 4'd8;
            ways_in_use_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_data[3:0];
                CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Address split with clamped field widths; the set index is reduced modulo SETS
    // by a reciprocal multiplication that is exact for 8-bit indexes.
    always_comb
    begin
        ob       = (offset_bits_reg > 5'(MAX_OFFSET_BITS)) ? SH_W'(MAX_OFFSET_BITS)
                                                            : offset_bits_reg;
        ib       = ({1'b0, index_bits_reg} > 5'(MAX_INDEX_BITS)) ? SH_W'(MAX_INDEX_BITS)
                                                                  : {1'b0, index_bits_reg};
        shifted  = s_tdata >> ob;
        tag_calc = shifted >> ib;
        idx_raw  = shifted[MAX_INDEX_BITS-1:0] & MAX_INDEX_BITS'((9'd1 << ib) - 9'd1);
        idx_prod = {{(MOD_SH + 1){1'b0}}, idx_raw} * {{MAX_INDEX_BITS{1'b0}}, SET_RECIP};
        idx_quot = idx_prod[MAX_INDEX_BITS+MOD_SH-1:MOD_SH];
        set_idx  = SET_W'(32'(idx_raw) - 32'(idx_quot) * 32'(SETS));
        n_ways   = (ways_in_use_reg == 4'd0) ? 4'd1 : ways_in_use_reg;
    end

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer: clear sweep, then read, compare, write back.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:   if (accept) state_next = ST_LOOKUP;
            // Wait here while the previous result still occupies the output register.
            ST_LOOKUP: if (!out_valid_reg || m_tready) state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Access word capture, and capture of the lookup result and updated row.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag_reg <= tag_calc;
            set_reg <= set_idx;
            wr_reg  <= s_tuser;
            for (int i = 0; i < WAYS; i++)
            begin
                use_reg[i] <= (4'(i) < n_ways);
            end
        end
        if (state_reg == ST_LOOKUP)
        begin
            res_reg <= res;
            row_reg <= {rank_new, dirty_new, valid_new, tags_new};
        end
    end

    assign {rank, dirty, valid, tags} = rd_data;

    salc_lookup #(
        .WAYS   (WAYS),
        .TAG_W  (TAG_W),
        .RANK_W (RANK_W)
    ) u_lookup (
        .tags      (tags),
        .valid     (valid),
        .dirty     (dirty),
        .rank      (rank),
        .tag       (tag_reg),
        .wr        (wr_reg),
        .in_use    (use_reg),
        .res       (res),
        .tags_new  (tags_new),
        .valid_new (valid_new),
        .dirty_new (dirty_new),
        .rank_new  (rank_new)
    );

    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_reg : set_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : row_reg;

    salc_set_mem #(
        .SETS  (SETS),
        .ROW_W (ROW_W)
    ) u_mem (
        .clk     (clk),
        .rd_addr (accept ? set_idx : set_reg),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata)
    );

    assign evt.wr  = wr_reg;
    assign evt.hit = res_reg.hit;
    assign evt.wb  = res_reg.writeback;

    salc_stats u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .bump   (state_reg == ST_WRITE),
        .evt    (evt),
        .counts (counts)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_WRITE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            out_head_reg <= {res_reg.way, res_reg.writeback, res_reg.hit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, counts, out_head_reg};

endmodule

// ----- rtl/core/salc_checker.sv -----
// Port-level checker of the cache tag block, bound to the top level.
module salc_checker
    import salc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [263:0] m_tdata
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // After an accepted word the input stays closed through the lookup and write-back of that word.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("ready too early after an access");

    // With the output register free, an accepted word is answered after lookup and write-back.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (!m_tvalid || m_tready) |=> !m_tvalid ##1 !m_tvalid
        ##1 m_tvalid)
        else $error("result not on time");

    // A hit never flags a writeback.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("writeback on hit");

endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
